// ----- design/zlib_fixed_huffman_literal_encoder_defines.svh -----
// Assertion macros used by the checker file of the literal encoder.
`ifndef ZLIB_FIXED_HUFFMAN_LITERAL_ENCODER_DEFINES_SVH
`define ZLIB_FIXED_HUFFMAN_LITERAL_ENCODER_DEFINES_SVH

// Same-cycle implication, off during reset.
`define ZFHL_ASSERT_NOW(lbl, clk, rst_n, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
		else $error("zfhl check failed");

// Next-cycle implication, off during reset.
`define ZFHL_ASSERT_NEXT(lbl, clk, rst_n, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
		else $error("zfhl check failed");

// Same-cycle implication that also holds during reset.
`define ZFHL_ASSERT_ALWAYS(lbl, clk, ant, con) \
	lbl: assert property (@(posedge clk) (ant) |-> (con)) \
		else $error("zfhl check failed");

`endif

// ----- design/zfhl_pkg.sv -----
// Package: constants and command type of the fixed-Huffman literal encoder.
`timescale 1ns / 1ps
`default_nettype none
package zfhl_pkg;

	localparam logic [16:0] ADLER_MOD     = 17'd65521;
	localparam logic [7:0]  LIT_SPLIT     = 8'd144;
	localparam logic [8:0]  LIT_BASE_LOW  = 9'h030;
	localparam logic [8:0]  LIT_BASE_HIGH = 9'h190;
	localparam logic [7:0]  ZLIB_CMF      = 8'h78;
	localparam logic [7:0]  ZLIB_FLG      = 8'h9C;
	// BFINAL=1, BTYPE=01, in sending order from bit 0
	localparam logic [2:0]  BLK_HDR       = 3'b011;
	localparam logic [4:0]  BLK_HDR_LEN   = 5'd3;
	localparam logic [4:0]  EOB_LEN       = 5'd7;
	localparam int          CODE_W        = 19;
	localparam int          NB_W          = 5;
	localparam int          BUF_W         = 26;

	typedef struct packed {
		logic              zhdr;
		logic              trl;
		logic              last;
		logic [NB_W-1:0]   nbits;
		logic [CODE_W-1:0] bits;
		logic [15:0]       sum_high;
		logic [15:0]       sum_low;
	} cmd_t;

endpackage
`default_nettype wire

// ----- design/zfhl_ifs.sv -----
// Channel interfaces: data bytes in, compressed bytes out, configuration write.
`timescale 1ns / 1ps
`default_nettype none
interface zfhl_data_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;
	modport source (output valid, output data_byte, output last, input ready);
	modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface zfhl_zs_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;
	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

interface zfhl_cfg_if;
	logic valid;
	logic ready;
	logic wrap_zlib;
	modport source (output valid, output wrap_zlib, input ready);
	modport sink (input valid, input wrap_zlib, output ready);
endinterface
`default_nettype wire

// ----- design/zfhl_front.sv -----
// Front end: accepts data bytes, keeps Adler-32 and stream state, builds bit commands.
`timescale 1ns / 1ps
`default_nettype none
module zfhl_front import zfhl_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    wrap_zlib,
	zfhl_data_if.sink    data,
	input  wire logic    q_full,
	output logic         push,
	output cmd_t         cmd
);

	logic        started_q;
	logic [15:0] sum_low_q;
	logic [15:0] sum_high_q;
	logic [15:0] low_n;
	logic [15:0] high_n;
	logic [16:0] low_sum;
	logic [16:0] high_sum;
	logic        long_code;
	logic [8:0]  code;
	logic [8:0]  rev;
	logic [4:0]  lit_len;

	function automatic logic [15:0] adler_mod(input logic [16:0] s);
		logic [16:0] r;
		r = (s >= ADLER_MOD) ? s - ADLER_MOD : s;
		return r[15:0];
	endfunction

	assign data.ready = !q_full;
	assign push       = data.valid && data.ready;

	assign low_sum  = {1'b0, sum_low_q} + {9'd0, data.data_byte};
	assign low_n    = adler_mod(low_sum);
	assign high_sum = {1'b0, sum_high_q} + {1'b0, low_n};
	assign high_n   = adler_mod(high_sum);

	assign long_code = data.data_byte >= LIT_SPLIT;
	assign lit_len   = long_code ? 5'd9 : 5'd8;

	always_comb begin
		if (long_code) begin
			code = LIT_BASE_HIGH + {1'b0, data.data_byte} - {1'b0, LIT_SPLIT};
		end else begin
			code = LIT_BASE_LOW + {1'b0, data.data_byte};
		end
	end

	// codes go out MSB first, so reverse into sending order
	always_comb begin
		rev = '0;
		if (long_code) begin
			for (int i = 0; i < 9; i++) begin
				rev[i] = code[8-i];
			end
		end else begin
			for (int i = 0; i < 8; i++) begin
				rev[i] = code[7-i];
			end
		end
	end

	always_comb begin
		cmd.zhdr     = !started_q && wrap_zlib;
		cmd.trl      = data.last && wrap_zlib;
		cmd.last     = data.last;
		cmd.bits     = started_q ? {10'd0, rev} : {7'd0, rev, BLK_HDR};
		cmd.nbits    = (started_q ? 5'd0 : BLK_HDR_LEN) + lit_len +
			(data.last ? EOB_LEN : 5'd0);
		cmd.sum_high = high_n;
		cmd.sum_low  = low_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q  <= 1'b0;
			sum_low_q  <= 16'd1;
			sum_high_q <= 16'd0;
		end else if (push) begin
			if (data.last) begin
				started_q  <= 1'b0;
				sum_low_q  <= 16'd1;
				sum_high_q <= 16'd0;
			end else begin
				started_q  <= 1'b1;
				sum_low_q  <= low_n;
				sum_high_q <= high_n;
			end
		end
	end

endmodule
`default_nettype wire

// ----- design/zfhl_queue.sv -----
// Command queue between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module zfhl_queue import zfhl_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t wdata,
	output logic      full,
	input  wire logic pop,
	output logic      empty,
	output cmd_t      rdata
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full  = count_q == CW'(DEPTH);
	assign empty = count_q == '0;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= ptr_inc(wptr_q);
			end
			if (pop) begin
				rptr_q <= ptr_inc(rptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- design/zfhl_back.sv -----
// Back end: packs command bits into bytes, adds zlib header and trailer.
`timescale 1ns / 1ps
`default_nettype none
module zfhl_back import zfhl_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t cmd,
	input  wire logic empty,
	output logic      pop,
	zfhl_zs_if.source zs
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_HDR0 = 3'd1;
	localparam logic [2:0] ST_HDR1 = 3'd2;
	localparam logic [2:0] ST_BITS = 3'd3;
	localparam logic [2:0] ST_TRL0 = 3'd4;
	localparam logic [2:0] ST_TRL1 = 3'd5;
	localparam logic [2:0] ST_TRL2 = 3'd6;
	localparam logic [2:0] ST_TRL3 = 3'd7;

	logic [2:0]       state_q;
	logic [2:0]       state_d;
	logic [BUF_W-1:0] buf_q;
	logic [BUF_W-1:0] buf_d;
	logic [NB_W-1:0]  tot_q;
	logic [NB_W-1:0]  tot_d;
	logic             last_q;
	logic             trl_q;
	logic [15:0]      sh_q;
	logic [15:0]      sl_q;
	logic             ov_q;
	logic [7:0]       ob_q;
	logic             ol_q;
	logic             slot;
	logic             load;
	logic             emit;
	logic [7:0]       eb;
	logic             el;
	logic [2:0]       end_state;

	assign slot        = !ov_q || zs.ready;
	assign end_state   = trl_q ? ST_TRL0 : ST_IDLE;
	assign zs.valid    = ov_q;
	assign zs.out_byte = ob_q;
	assign zs.out_last = ol_q;
	assign pop         = load;

	always_comb begin
		state_d = state_q;
		buf_d   = buf_q;
		tot_d   = tot_q;
		load    = 1'b0;
		emit    = 1'b0;
		eb      = '0;
		el      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				load = !empty;
			end
			ST_HDR0: begin
				if (slot) begin
					emit    = 1'b1;
					eb      = ZLIB_CMF;
					state_d = ST_HDR1;
				end
			end
			ST_HDR1: begin
				if (slot) begin
					emit    = 1'b1;
					eb      = ZLIB_FLG;
					state_d = ST_BITS;
				end
			end
			ST_BITS: begin
				if (tot_q >= NB_W'(8)) begin
					if (slot) begin
						emit  = 1'b1;
						eb    = buf_q[7:0];
						el    = last_q && !trl_q && (tot_q == NB_W'(8));
						buf_d = buf_q >> 8;
						tot_d = tot_q - NB_W'(8);
					end
				end else if (last_q) begin
					if (tot_q == '0) begin
						state_d = end_state;
					end else if (slot) begin
						emit    = 1'b1;
						eb      = buf_q[7:0];
						el      = !trl_q;
						buf_d   = '0;
						tot_d   = '0;
						state_d = end_state;
					end
				end else if (!empty) begin
					load = 1'b1;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_TRL0: begin
				if (slot) begin
					emit    = 1'b1;
					eb      = sh_q[15:8];
					state_d = ST_TRL1;
				end
			end
			ST_TRL1: begin
				if (slot) begin
					emit    = 1'b1;
					eb      = sh_q[7:0];
					state_d = ST_TRL2;
				end
			end
			ST_TRL2: begin
				if (slot) begin
					emit    = 1'b1;
					eb      = sl_q[15:8];
					state_d = ST_TRL3;
				end
			end
			ST_TRL3: begin
				if (slot) begin
					emit    = 1'b1;
					eb      = sl_q[7:0];
					el      = 1'b1;
					state_d = ST_IDLE;
				end
			end
		endcase
		if (load) begin
			// residual bits stay below, new bits go on top
			buf_d   = BUF_W'(buf_q[7:0]) | (BUF_W'(cmd.bits) << tot_q[2:0]);
			tot_d   = tot_q + cmd.nbits;
			state_d = cmd.zhdr ? ST_HDR0 : ST_BITS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			buf_q   <= '0;
			tot_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			buf_q   <= buf_d;
			tot_q   <= tot_d;
			if (emit) begin
				ov_q <= 1'b1;
			end else if (zs.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			last_q <= cmd.last;
			trl_q  <= cmd.trl;
			sh_q   <= cmd.sum_high;
			sl_q   <= cmd.sum_low;
		end
		if (emit) begin
			ob_q <= eb;
			ol_q <= el;
		end
	end

endmodule
`default_nettype wire

// ----- design/zlib_fixed_huffman_literal_encoder.sv -----
// Top level of the fixed-Huffman deflate literal encoder with optional zlib wrap.
// Channels: data takes one data byte per item with a last mark; zstream gives
// one compressed byte per item, out_last on the final byte of a stream; cfg
// writes wrap_zlib (1 after reset) and is always ready.
// Each stream is one fixed-Huffman deflate block of literals, preceded by
// 78 9C and followed by the big-endian Adler-32 when wrap_zlib is set.
// The front end classifies a byte and updates Adler-32 in the cycle it is
// accepted; the command then waits in a QUEUE_DEPTH-entry queue.
// The back end pops a command from the queue when it is idle or needs more bits,
// and drives bytes into the output register while zstream can take them; the
// zlib header, when due, goes out before the first literal byte of a stream.
// The back end's byte packer limits the rate; the queue takes further bytes while
// the packer works, and the last item adds its flush and trailer bytes.
// data.ready drops only while the queue is full.
// When zstream stalls, the output register holds its byte and the queue fills.
// Reset clears the queue, the bit buffer and the stream state and sets
// wrap_zlib to 1; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module zlib_fixed_huffman_literal_encoder import zfhl_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	zfhl_data_if.sink data,
	zfhl_zs_if.source zstream,
	zfhl_cfg_if.sink  cfg
);

	logic wrap_q;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;
	cmd_t cmd_in;
	cmd_t cmd_out;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_q <= 1'b1;
		end else if (cfg.valid && cfg.ready) begin
			wrap_q <= cfg.wrap_zlib;
		end
	end

	zfhl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.wrap_zlib (wrap_q),
		.data      (data),
		.q_full    (q_full),
		.push      (push),
		.cmd       (cmd_in)
	);

	zfhl_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd_in),
		.full   (q_full),
		.pop    (pop),
		.empty  (q_empty),
		.rdata  (cmd_out)
	);

	zfhl_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_out),
		.empty  (q_empty),
		.pop    (pop),
		.zs     (zstream)
	);

endmodule
`default_nettype wire

// ----- design/zfhl_checker.sv -----
// Port-level checks on the literal encoder and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "zlib_fixed_huffman_literal_encoder_defines.svh"
module zfhl_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       in_last,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       out_last
);

	logic [7:0] open_q;
	logic       inc;
	logic       dec;

	assign inc = in_valid && in_ready && in_last;
	assign dec = out_valid && out_ready && out_last;

	// streams whose last byte went in but whose last output is not yet taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else if (inc && !dec) begin
			open_q <= open_q + 1'b1;
		end else if (dec && !inc) begin
			open_q <= open_q - 1'b1;
		end
	end

	`ZFHL_ASSERT_NEXT(a_valid_held, clk, arst_n, out_valid && !out_ready, out_valid)
	`ZFHL_ASSERT_NEXT(a_payload_held, clk, arst_n, out_valid && !out_ready, $stable(out_byte) && $stable(out_last))
	`ZFHL_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n, !out_valid)
	`ZFHL_ASSERT_NOW(a_end_has_stream, clk, arst_n, dec, open_q != 8'd0)

endmodule

bind zlib_fixed_huffman_literal_encoder zfhl_checker u_zfhl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (data.valid),
	.in_ready  (data.ready),
	.in_last   (data.last),
	.out_valid (zstream.valid),
	.out_ready (zstream.ready),
	.out_byte  (zstream.out_byte),
	.out_last  (zstream.out_last)
);
`default_nettype wire

// ----- test/zlib_fixed_huffman_literal_encoder_tb.sv -----
// Self-checking testbench for the fixed-Huffman literal encoder, with its own bit-level predictor.
`timescale 1ns / 1ps
module zlib_fixed_huffman_literal_encoder_tb;
	import zfhl_pkg::*;

	localparam int LIT_ROWS       = 20;
	localparam int PHASES         = 5;
	localparam int PHASE_LITS     = 12;
	localparam int ADLER_RUN      = 30;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int DRAIN_SETTLE   = 16;

	localparam int   PH_SEND_IDLE [PHASES] = '{0, 76, 0, 32, 0};
	localparam int   PH_RECV_STALL[PHASES] = '{0, 0, 76, 32, 0};
	localparam logic PH_WRAP      [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

	// one literal item; typed holds hand-worked output bytes, first byte in the top bits
	typedef struct packed {
		logic [7:0]  data_byte;
		logic        last;
		logic [3:0]  n_typed;
		logic [71:0] typed;
	} lit_item_t;

	typedef struct packed {
		logic      set_wrap;
		logic      wrap_val;
		lit_item_t item;
	} lit_row_t;

	typedef struct packed {
		logic [7:0] value;
		logic       fin;
	} zbyte_t;

	localparam lit_row_t LIT_TABLE [LIT_ROWS] = '{
		{1'b0, 1'b0, 8'h00, 1'b1, 4'd9, 72'h78_9C_63_00_00_00_01_00_01},
		{1'b1, 1'b0, 8'h00, 1'b1, 4'd3, 72'h63_00_00_00_00_00_00_00_00},
		{1'b0, 1'b0, 8'hFF, 1'b1, 4'd3, 72'hFB_0F_00_00_00_00_00_00_00},
		{1'b0, 1'b0, 8'h8F, 1'b0, 4'd0, 72'h0},
		{1'b0, 1'b0, 8'h90, 1'b0, 4'd0, 72'h0},
		{1'b0, 1'b0, 8'h00, 1'b0, 4'd0, 72'h0},
		{1'b0, 1'b0, 8'hFF, 1'b0, 4'd0, 72'h0},
		{1'b0, 1'b0, 8'h55, 1'b0, 4'd0, 72'h0},
		{1'b0, 1'b0, 8'hAA, 1'b1, 4'd0, 72'h0},
		{1'b1, 1'b1, 8'h7F, 1'b0, 4'd0, 72'h0},
		{1'b0, 1'b0, 8'h80, 1'b0, 4'd0, 72'h0},
		{1'b0, 1'b0, 8'h01, 1'b0, 4'd0, 72'h0},
		{1'b1, 1'b0, 8'hFE, 1'b1, 4'd0, 72'h0},
		{1'b0, 1'b0, 8'h12, 1'b0, 4'd0, 72'h0},
		{1'b1, 1'b1, 8'hC3, 1'b1, 4'd0, 72'h0},
		{1'b0, 1'b0, 8'h61, 1'b1, 4'd0, 72'h0},
		{1'b0, 1'b0, 8'hFF, 1'b0, 4'd0, 72'h0},
		{1'b0, 1'b0, 8'hFF, 1'b0, 4'd0, 72'h0},
		{1'b0, 1'b0, 8'hFF, 1'b0, 4'd0, 72'h0},
		{1'b0, 1'b0, 8'hFF, 1'b1, 4'd0, 72'h0}
	};

	logic clk;
	logic arst_n;

	zfhl_data_if lit_ch();
	zfhl_zs_if   zs_ch();
	zfhl_cfg_if  cfg_ch();

	zlib_fixed_huffman_literal_encoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.data(lit_ch),
		.zstream(zs_ch),
		.cfg(cfg_ch)
	);

	lit_item_t feed_q[$];
	zbyte_t    zbytes_due[$];
	zbyte_t    step_out[$];

	// predictor state
	logic        wrap_model = 1'b1;
	logic [7:0]  pk_acc     = '0;
	logic [2:0]  pk_cnt     = '0;
	logic        pk_started = 1'b0;
	logic [16:0] ad_low     = 17'd1;
	logic [16:0] ad_high    = '0;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_req       = 0;
	int hold_seen      = 0;
	int hold_left      = 0;
	bit data_taken     = 1'b0;

	int bad_count    = 0;
	int lits_taken   = 0;
	int streams_done = 0;
	int zbytes_seen  = 0;
	int wrap_writes  = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("zlib_fixed_huffman_literal_encoder_tb NOT OK");
		$finish;
	end

	function automatic void put_zbyte(input logic [7:0] v);
		step_out.push_back(zbyte_t'{v, 1'b0});
	endfunction

	function automatic void put_zbit(input logic v);
		if (v) begin
			pk_acc[pk_cnt] = 1'b1;
		end
		if (pk_cnt == 3'd7) begin
			put_zbyte(pk_acc);
			pk_acc = '0;
			pk_cnt = '0;
		end else begin
			pk_cnt = pk_cnt + 3'd1;
		end
	endfunction

	function automatic void put_code(input logic [8:0] code, input int len);
		for (int i = len - 1; i >= 0; i--) begin
			put_zbit(code[i]);
		end
	endfunction

	// bytes that one literal releases, in step_out
	function automatic void encode_literal(input logic [7:0] d, input logic lst);
		step_out.delete();
		if (!pk_started) begin
			if (wrap_model) begin
				put_zbyte(ZLIB_CMF);
				put_zbyte(ZLIB_FLG);
			end
			for (int i = 0; i < BLK_HDR_LEN; i++) begin
				put_zbit(BLK_HDR[i]);
			end
			pk_started = 1'b1;
		end
		ad_low = ad_low + d;
		if (ad_low >= ADLER_MOD) begin
			ad_low = ad_low - ADLER_MOD;
		end
		ad_high = ad_high + ad_low;
		if (ad_high >= ADLER_MOD) begin
			ad_high = ad_high - ADLER_MOD;
		end
		if (d < LIT_SPLIT) begin
			put_code(LIT_BASE_LOW + d, 8);
		end else begin
			put_code(LIT_BASE_HIGH + (d - LIT_SPLIT), 9);
		end
		if (lst) begin
			put_code('0, EOB_LEN);
			if (pk_cnt != 0) begin
				put_zbyte(pk_acc);
			end
			if (wrap_model) begin
				put_zbyte(ad_high[15:8]);
				put_zbyte(ad_high[7:0]);
				put_zbyte(ad_low[15:8]);
				put_zbyte(ad_low[7:0]);
			end
			step_out[step_out.size() - 1].fin = 1'b1;
			pk_acc     = '0;
			pk_cnt     = '0;
			pk_started = 1'b0;
			ad_low     = 17'd1;
			ad_high    = '0;
		end
	endfunction

	function automatic void push_random_literal();
		logic [7:0] d;
		logic [7:0] edges [4];
		edges = '{8'h00, 8'h8F, 8'h90, 8'hFF};
		if ($urandom_range(0, 3) == 0) begin
			d = edges[$urandom_range(0, 3)];
		end else begin
			d = 8'($urandom_range(0, 255));
		end
		feed_q.push_back({d, 1'($urandom_range(0, 4) == 0), 4'd0, 72'd0});
	endfunction

	// monitor: predicts on each accepted literal, checks each compressed byte
	always @(posedge clk) begin
		lit_item_t it;
		zbyte_t    want;
		data_taken = lit_ch.valid && lit_ch.ready;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				wrap_model = cfg_ch.wrap_zlib;
				wrap_writes++;
			end
			if (data_taken) begin
				it = feed_q.pop_front();
				encode_literal(it.data_byte, it.last);
				if (it.n_typed != 0) begin
					for (int k = 0; k < it.n_typed; k++) begin
						zbytes_due.push_back(zbyte_t'{it.typed[71 - 8 * k -: 8],
							k == it.n_typed - 1});
					end
				end else begin
					foreach (step_out[k]) begin
						zbytes_due.push_back(step_out[k]);
					end
				end
				lits_taken++;
				if (it.last) begin
					streams_done++;
				end
			end
			if (zs_ch.valid && zs_ch.ready) begin
				if (zbytes_due.size() == 0) begin
					if (bad_count < 10) begin
						$display("unexpected byte %0d: got %h/%b", zbytes_seen,
							zs_ch.out_byte, zs_ch.out_last);
					end
					bad_count++;
				end else begin
					want = zbytes_due.pop_front();
					if (want.value !== zs_ch.out_byte || want.fin !== zs_ch.out_last) begin
						if (bad_count < 10) begin
							$display("mismatch at byte %0d: expected %h/%b, got %h/%b",
								zbytes_seen, want.value, want.fin,
								zs_ch.out_byte, zs_ch.out_last);
						end
						bad_count++;
					end
				end
				zbytes_seen++;
			end
		end
	end

	// literal sender
	always @(negedge clk) begin
		if (!lit_ch.valid || data_taken) begin
			if (arst_n && feed_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				lit_ch.valid     <= 1'b1;
				lit_ch.data_byte <= feed_q[0].data_byte;
				lit_ch.last      <= feed_q[0].last;
			end else begin
				lit_ch.valid <= 1'b0;
			end
		end
	end

	// compressed byte receiver, with long hold-off on request
	always @(negedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = RX_HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			zs_ch.ready <= 1'b0;
		end else begin
			zs_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	task automatic drain();
		while (feed_q.size() != 0 || zbytes_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_SETTLE) @(posedge clk);
	endtask

	task automatic write_wrap(input logic v);
		@(negedge clk);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.wrap_zlib <= v;
		do begin
			@(posedge clk);
		end while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		arst_n           = 1'b0;
		lit_ch.valid     = 1'b0;
		lit_ch.data_byte = '0;
		lit_ch.last      = 1'b0;
		zs_ch.ready      = 1'b0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.wrap_zlib = 1'b1;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		for (int r = 0; r < LIT_ROWS; r++) begin
			if (LIT_TABLE[r].set_wrap) begin
				drain();
				write_wrap(LIT_TABLE[r].wrap_val);
			end
			feed_q.push_back(LIT_TABLE[r].item);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			write_wrap(PH_WRAP[ph]);
			send_idle_pct  = PH_SEND_IDLE[ph];
			recv_stall_pct = PH_RECV_STALL[ph];
			if (ph == PHASES - 1) begin
				hold_req++;
			end
			for (int k = 0; k < PHASE_LITS; k++) begin
				push_random_literal();
			end
		end

		// run of high bytes so that the high Adler sum passes the modulus
		drain();
		write_wrap(1'b1);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		for (int k = 0; k < ADLER_RUN; k++) begin
			feed_q.push_back({8'($urandom_range(252, 255)), 1'(k == ADLER_RUN - 1),
				4'd0, 72'd0});
		end
		drain();

		$display("%0d literals in %0d closed streams gave %0d compressed bytes",
			lits_taken, streams_done, zbytes_seen);
		$display("%0d wrap writes, both modes, mid-stream changes and an input stall",
			wrap_writes);
		if (bad_count == 0) begin
			$display("zlib_fixed_huffman_literal_encoder_tb OK");
		end else begin
			$display("zlib_fixed_huffman_literal_encoder_tb NOT OK");
		end
		$finish;
	end

endmodule
